FILE: src/hmi_pkg.sv
// hmi_pkg: types and constants shared by the histogram mode interpolator.
// Used by hmi_ctrl, hmi_datapath, histogram_mode_interpolate and hmi_checker.
// No dependencies.
package hmi_pkg;

    // Register indexes of the configuration port
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_EDGE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH = 1'b1;

    localparam logic [31:0] LOW_EDGE_RESET  = 32'd0;
    localparam logic [30:0] BIN_WIDTH_RESET = 31'd65536;

    // Quotient bits produced by the restoring divider (quotient <= bin_width < 2^31)
    localparam int DIV_STEPS = 32;

    // How the bin offset is formed
    localparam logic [1:0] SEL_EDGE   = 2'd0;  // two equal bins: boundary between them
    localparam logic [1:0] SEL_MID    = 2'd1;  // midpoint of the peak bin
    localparam logic [1:0] SEL_INTERP = 2'd2;  // parabolic interpolation

    typedef struct packed {
        logic [31:0] bin_count;
        logic        last;
    } item_t;

    typedef struct packed {
        logic signed [31:0] mode_value;
        logic [11:0]        peak_bin;
        logic               saturated;
    } result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic track;     // take one bin beat into the peak tracker
        logic mul_num;   // width*dh1, load divider, pick offset form
        logic div_step;  // one restoring divide step
        logic mul_base;  // width*b or width*(2b+1), round quotient
        logic finish;    // form mode, register result, clear tracker
    } cmd_t;

endpackage

FILE: src/hmi_ctrl.sv
// hmi_ctrl: sequencer for the histogram mode interpolator.
// Accepts bin beats while idle and steps the datapath through the final math.
// Depends on hmi_pkg.
module hmi_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          last,
    output logic          busy,
    output hmi_pkg::cmd_t cmd
);
    import hmi_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_BASE = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    localparam int STEP_W = $clog2(DIV_STEPS);

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.track = 1'b1;
                    if (last)
                        state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_num = 1'b1;
                step_next   = '0;
                state_next  = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = S_BASE;
            end
            S_BASE:
            begin
                cmd.mul_base = 1'b1;
                state_next   = S_FIN;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

FILE: src/hmi_datapath.sv
// hmi_datapath: peak tracker, shared multiplier, restoring divider and
// saturating output stage of the histogram mode interpolator.
// Depends on hmi_pkg; driven by hmi_ctrl.
module hmi_datapath #(
    parameter int MAX_BINS = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  hmi_pkg::cmd_t                   cmd,
    input  hmi_pkg::item_t                  item,
    input  logic                            cfg_we,
    input  logic [hmi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data,
    output logic                            done,
    output hmi_pkg::result_t                result
);
    import hmi_pkg::*;

    localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CNT_W = $clog2(MAX_BINS + 1);

    localparam logic signed [49:0] MODE_MAX = 50'sd2147483647;
    localparam logic signed [49:0] MODE_MIN = -50'sd2147483648;

    // configuration
    logic [31:0] low_edge_reg;
    logic [30:0] bin_width_reg;

    // peak tracker
    logic [31:0]      prev_reg, prev_next;
    logic [31:0]      peak_reg, peak_next;
    logic [IDX_W-1:0] pidx_reg, pidx_next;
    logic [31:0]      left_reg, left_next;
    logic [31:0]      right_reg, right_next;
    logic             rp_reg, rp_next;
    logic [CNT_W-1:0] seen_reg, seen_next;

    // arithmetic
    logic [1:0]  sel_reg;
    logic [32:0] den_reg;
    logic [32:0] rem_reg;
    logic [31:0] sh_reg;
    logic [31:0] q_reg;
    logic [31:0] qr_reg;
    logic [47:0] base_reg;
    logic        done_reg;
    result_t     result_reg;

    logic [31:0]      dh1, dh2;
    logic [31:0]      mul_b;
    logic [62:0]      prod;
    logic [CNT_W:0]   n_ext, b_inc;
    logic [1:0]       sel_now;
    logic [33:0]      trial;
    logic             trial_ge;
    logic             round_up;
    logic [48:0]      offset;
    logic signed [49:0] mode_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_edge_reg  <= LOW_EDGE_RESET;
            bin_width_reg <= BIN_WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LOW_EDGE:  low_edge_reg  <= cfg_data;
                CFG_BIN_WIDTH: bin_width_reg <= cfg_data[30:0];
                default:       ;
            endcase
        end
    end

    // tracker next state
    always_comb
    begin
        prev_next  = prev_reg;
        peak_next  = peak_reg;
        pidx_next  = pidx_reg;
        left_next  = left_reg;
        right_next = right_reg;
        rp_next    = rp_reg;
        seen_next  = seen_reg;
        if (cmd.track && (seen_reg < CNT_W'(MAX_BINS)))
        begin
            if (seen_reg == '0)
            begin
                peak_next = item.bin_count;
                pidx_next = '0;
                left_next = '0;
                rp_next   = 1'b1;
            end
            else
            begin
                if (rp_reg)
                begin
                    right_next = item.bin_count;
                    rp_next    = 1'b0;
                end
                if (item.bin_count > peak_reg)
                begin
                    peak_next = item.bin_count;
                    pidx_next = seen_reg[IDX_W-1:0];
                    left_next = prev_reg;
                    rp_next   = 1'b1;
                end
            end
            prev_next = item.bin_count;
            seen_next = seen_reg + 1'b1;
        end
        if (cmd.finish)
        begin
            prev_next  = '0;
            peak_next  = '0;
            pidx_next  = '0;
            left_next  = '0;
            right_next = '0;
            rp_next    = 1'b0;
            seen_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            peak_reg  <= '0;
            pidx_reg  <= '0;
            left_reg  <= '0;
            right_reg <= '0;
            rp_reg    <= 1'b0;
            seen_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            prev_reg  <= prev_next;
            peak_reg  <= peak_next;
            pidx_reg  <= pidx_next;
            left_reg  <= left_next;
            right_reg <= right_next;
            rp_reg    <= rp_next;
            seen_reg  <= seen_next;
            done_reg  <= cmd.finish;
        end
    end

    // offset form, decided once the last bin is in
    assign n_ext = (CNT_W+1)'(seen_reg);
    assign b_inc = (CNT_W+1)'(pidx_reg) + 1'b1;

    always_comb
    begin
        if ((n_ext == (CNT_W+1)'(2)) && (pidx_reg == '0) && (right_reg == peak_reg))
            sel_now = SEL_EDGE;
        else if ((n_ext <= (CNT_W+1)'(2)) || (pidx_reg == '0) || (b_inc >= n_ext))
            sel_now = SEL_MID;
        else
            sel_now = SEL_INTERP;
    end

    // shared 31x32 multiplier
    assign dh1   = peak_reg - left_reg;
    assign dh2   = peak_reg - right_reg;
    assign mul_b = cmd.mul_num ? dh1 :
                   (sel_reg == SEL_MID) ? 32'({pidx_reg, 1'b1}) : 32'(pidx_reg);
    assign prod  = {32'd0, bin_width_reg} * {31'd0, mul_b};

    // restoring divide step; quotient fits 32 bits, so the high part of
    // the numerator is already below the divisor
    assign trial    = {rem_reg, sh_reg[31]};
    assign trial_ge = (trial >= {1'b0, den_reg});
    assign round_up = ({rem_reg, 1'b0} >= {1'b0, den_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.mul_num)
        begin
            rem_reg <= {2'b00, prod[62:32]};
            sh_reg  <= prod[31:0];
            den_reg <= {1'b0, dh1} + {1'b0, dh2};
            sel_reg <= sel_now;
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? 33'(trial - {1'b0, den_reg}) : trial[32:0];
            q_reg   <= {q_reg[30:0], trial_ge};
            sh_reg  <= {sh_reg[30:0], 1'b0};
        end
        if (cmd.mul_base)
        begin
            base_reg <= prod[47:0];
            qr_reg   <= q_reg + 32'(round_up);
        end
        if (cmd.finish)
            result_reg <= '{mode_value: (mode_full > MODE_MAX) ? 32'sh7FFFFFFF :
                                        (mode_full < MODE_MIN) ? 32'sh80000000 :
                                        mode_full[31:0],
                            peak_bin:   12'(pidx_reg),
                            saturated:  (mode_full > MODE_MAX) || (mode_full < MODE_MIN)};
    end

    always_comb
    begin
        case (sel_reg)
            SEL_EDGE:   offset = 49'(bin_width_reg);
            SEL_INTERP: offset = {1'b0, base_reg} + 49'(qr_reg);
            default:    offset = ({1'b0, base_reg} + 49'd1) >> 1;
        endcase
    end

    assign mode_full = $signed({{18{low_edge_reg[31]}}, low_edge_reg}) + $signed({1'b0, offset});

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: src/histogram_mode_interpolate.sv
// histogram_mode_interpolate: top level of the histogram mode estimator.
// Instantiates hmi_ctrl and hmi_datapath; depends on hmi_pkg.
//
// Channel  | Ports                          | Beat taken when
// ---------+--------------------------------+------------------------------
// bins in  | start, busy, item              | start && !busy at clk rise
// result   | done, result                   | done high (one cycle, no stall)
// config   | cfg_we, cfg_index, cfg_data    | cfg_we high at clk rise
//
// The tracker keeps up at one bin per clock while busy is low.
// The beat with last set starts a run: one multiply, 32 divide steps
// of the restoring divider, one multiply, one output step. busy is high
// through that run and done strobes for one cycle as busy drops.
// Reset (rst_n, async, active low) restores low_edge = 0, bin_width = 1.0
// and an empty histogram. The result side cannot stall.
module histogram_mode_interpolate #(
    parameter int MAX_BINS = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  hmi_pkg::item_t                  item,
    output logic                            done,
    output hmi_pkg::result_t                result,
    input  logic                            cfg_we,
    input  logic [hmi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data
);
    import hmi_pkg::*;

    cmd_t cmd;

    // sequencer: accepts bin beats, then walks the final math
    hmi_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .last  (item.last),
        .busy  (busy),
        .cmd   (cmd)
    );

    // tracker, multiplier, divider and saturating output register
    hmi_datapath #(
        .MAX_BINS (MAX_BINS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

endmodule

FILE: src/hmi_checker.sv
// hmi_checker: port-level assertions for histogram_mode_interpolate,
// attached by the bind at the end of this file. Depends on hmi_pkg.
module hmi_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input hmi_pkg::item_t   item,
    input logic             done,
    input hmi_pkg::result_t result
);
    import hmi_pkg::*;

    // a run only starts from an accepted last bin
    a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && item.last))
        else $error("busy rose without a last bin beat");

    // the result beat comes exactly as the run ends
    a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $fell(busy))
        else $error("result beat outside end of run");

    a_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("run ended without a result beat");

    // a clipped result sits on a limit
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.saturated) |->
            (result.mode_value == 32'sh7FFFFFFF || result.mode_value == 32'sh80000000))
        else $error("saturated result not at a limit");

endmodule

bind histogram_mode_interpolate hmi_checker u_hmi_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
);
